// File: hdl/gerq_pkg.sv
// ============================================================================
// gerq_pkg
// Shared types and constants of the gamepad edge and repeat qualifier.
// ============================================================================
package gerq_pkg;

  // Pad ports served by the state memory.
  localparam int NUM_PORTS = 4;
  localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Field widths of the sample and the result.
  localparam int PORT_W    = 2;
  localparam int BTN_W     = 16;
  localparam int AXIS_W    = 8;
  localparam int DIR_W     = 4;
  localparam int THRESH_W  = 7;
  localparam int HOLD_W    = 16;

  localparam int IN_DATA_W  = 40;   // 36 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 120;  // 113 bits of fields, padded to bytes

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD = 2'd1;

  localparam logic [BTN_W-1:0]    MASK_RESET   = 16'hFF3F;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd50;

  // Auto-repeat: first pulse at this count, then every REPEAT_EVERY counts.
  localparam logic [HOLD_W-1:0] REPEAT_FIRST = 16'd15;
  localparam int                REPEAT_EVERY = 5;
  localparam logic [2:0]        REPEAT_PHASE = 3'(15 % REPEAT_EVERY);

  // Direction bit positions.
  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  // One memory word: everything kept for one pad port.
  typedef struct packed {
    logic [BTN_W-1:0]  frame_prev_buttons;
    logic [BTN_W-1:0]  rise_accum;
    logic [BTN_W-1:0]  fall_accum;
    logic [BTN_W-1:0]  tick_prev_buttons;
    logic [DIR_W-1:0]  frame_prev_dirs;
    logic [DIR_W-1:0]  dir_rise_accum;
    logic [DIR_W-1:0]  dir_fall_accum;
    logic [DIR_W-1:0]  tick_prev_dirs;
    logic [BTN_W-1:0]  shown_rise;
    logic [BTN_W-1:0]  shown_fall;
    logic [BTN_W-1:0]  shown_before;
    logic [DIR_W-1:0]  shown_dir_rise;
    logic [DIR_W-1:0]  shown_dir_fall;
    logic [DIR_W-1:0]  shown_dir_before;
    logic              shown_repeat;
    logic [HOLD_W-1:0] held_ticks;
  } port_state_t;

  // Residue of a 16-bit count modulo 5. Since 16 is 1 mod 5, the nibble sum
  // keeps the residue; fold it once more and finish with compare-subtract.
  function automatic logic [2:0] mod5(input logic [HOLD_W-1:0] v);
    logic [5:0] s1;
    logic [4:0] s2;
    logic [4:0] r;
    s1 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
    s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
    if (s2 >= 5'd15) begin
      r = s2 - 5'd15;
    end else if (s2 >= 5'd10) begin
      r = s2 - 5'd10;
    end else if (s2 >= 5'd5) begin
      r = s2 - 5'd5;
    end else begin
      r = s2;
    end
    return r[2:0];
  endfunction

endpackage

// File: hdl/gamepad_edge_and_repeat_qualifier.sv
// ============================================================================
// gamepad_edge_and_repeat_qualifier
// Per-port button and stick edge qualification with tick-aligned publishing
// and auto-repeat, state held in a small per-port memory.
// ============================================================================
//
// Channel  Dir  Handshake            Contents
// -------  ---  -------------------  -----------------------------------------
// s_*      in   s_tvalid / s_tready  one pad sample per request
// m_*      out  m_tvalid / m_tready  one qualified result per sample
// cfg_*    in   cfg_valid/cfg_ready  register index + write data
//
// Flow: one sample per clock while m_tready stays high; the memory read
//   and the sample fields are registered when the sample is taken, and the
//   update stage then writes the result into the output register.
// The port state sits in a NUM_PORTS-deep memory, read when a sample is taken
//   and written back as the sample leaves the update stage. A sample whose
//   read meets the write of the one before it to the same port takes the
//   written word through the forwarding register instead.
// Reset: config registers return to defaults and the per-entry valid bits
//   clear, so every port reads as zero at once; no clearing pass is needed.
// Stalls: m_tready low with m_tvalid high holds the output register and the
//   update stage; the input side keeps taking samples while either has room.
//
module gamepad_edge_and_repeat_qualifier (
  input  logic                             clk,
  input  logic                             rst,
  // port_index[1:0], present[2], buttons_raw[18:3], axis_x[26:19],
  // axis_y[34:27], game_tick[35], zero[39:36]
  input  logic [gerq_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // button_now[15:0], button_rise[31:16], button_fall[47:32],
  // button_before[63:48], dir_now[67:64], dir_rise[71:68], dir_fall[75:72],
  // dir_before[79:76], repeat_pulse[80], hold_count[96:81],
  // axis_x_out[104:97], axis_y_out[112:105], zero[119:113]
  output logic [gerq_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gerq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gerq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gerq_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BTN_W-1:0]    button_mask;
  logic [THRESH_W-1:0] stick_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_mask     <= MASK_RESET;
      stick_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUTTON_MASK:     button_mask     <= cfg_data[BTN_W-1:0];
        REG_STICK_THRESHOLD: stick_threshold <= cfg_data[THRESH_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpack and handshake
  // --------------------------------------------------------------------------
  logic [PORT_W-1:0]  in_port;
  logic [PORT_AW-1:0] in_addr;
  logic               accept;
  logic               s1_valid;
  logic               s1_adv;

  assign in_port  = s_tdata[1:0];
  assign in_addr  = in_port[PORT_AW-1:0];

  // Update stage moves on when the output register is empty or being drained.
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Port state memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  port_state_t        mem [NUM_PORTS];
  port_state_t        rd_data;
  logic [NUM_PORTS-1:0] entry_valid;
  logic               wr_en;
  logic [PORT_AW-1:0] wr_addr;
  port_state_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data <= mem[in_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage registers
  // --------------------------------------------------------------------------
  logic [PORT_W-1:0]        s1_port;
  logic                     s1_present;
  logic [BTN_W-1:0]         s1_buttons;
  logic signed [AXIS_W-1:0] s1_ax;
  logic signed [AXIS_W-1:0] s1_ay;
  logic                     s1_tick;
  logic                     s1_rd_valid;
  logic                     s1_fwd_hit;
  port_state_t              s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_port     <= in_port;
      s1_present  <= s_tdata[2];
      s1_buttons  <= s_tdata[18:3];
      s1_ax       <= s_tdata[26:19];
      s1_ay       <= s_tdata[34:27];
      s1_tick     <= s_tdata[35];
      s1_rd_valid <= entry_valid[in_addr];
      // Catch the write-back landing on the same edge as this read.
      s1_fwd_hit  <= wr_en && (wr_addr == in_addr);
      s1_fwd_data <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Read-modify-write of one port's state
  // --------------------------------------------------------------------------
  port_state_t              st_cur;
  port_state_t              st_next;
  logic                     port_ok;
  logic [BTN_W-1:0]         cur;
  logic [DIR_W-1:0]         dir;
  logic signed [AXIS_W:0]   ax_w;
  logic signed [AXIS_W:0]   ay_w;
  logic signed [AXIS_W:0]   th_pos;
  logic signed [AXIS_W:0]   th_neg;
  logic [HOLD_W-1:0]        held_inc;
  logic                     held_same;
  logic [OUT_DATA_W-1:0]    result;

  assign port_ok = ({1'b0, s1_port} < 3'(NUM_PORTS));

  always_comb begin
    if (s1_fwd_hit) begin
      st_cur = s1_fwd_data;
    end else if (s1_rd_valid) begin
      st_cur = rd_data;
    end else begin
      st_cur = '0;
    end
  end

  always_comb begin
    cur    = s1_buttons & button_mask;
    ax_w   = {s1_ax[AXIS_W-1], s1_ax};
    ay_w   = {s1_ay[AXIS_W-1], s1_ay};
    th_pos = $signed({2'b00, stick_threshold});
    th_neg = -th_pos;

    // Negative side wins; at most one bit per axis.
    dir = '0;
    if (ax_w < th_neg) begin
      dir[DIR_LEFT] = 1'b1;
    end else if (ax_w > th_pos) begin
      dir[DIR_RIGHT] = 1'b1;
    end
    if (ay_w < th_neg) begin
      dir[DIR_DOWN] = 1'b1;
    end else if (ay_w > th_pos) begin
      dir[DIR_UP] = 1'b1;
    end

    held_inc  = st_cur.held_ticks + 16'd1;
    held_same = ((cur != '0) || (dir != '0)) &&
                (st_cur.tick_prev_buttons == cur) &&
                (st_cur.tick_prev_dirs == dir);

    // Gather edges every frame.
    st_next = st_cur;
    st_next.rise_accum     = st_cur.rise_accum | (cur & ~st_cur.frame_prev_buttons);
    st_next.fall_accum     = st_cur.fall_accum | (st_cur.frame_prev_buttons & ~cur);
    st_next.dir_rise_accum = st_cur.dir_rise_accum | (dir & ~st_cur.frame_prev_dirs);
    st_next.dir_fall_accum = st_cur.dir_fall_accum | (st_cur.frame_prev_dirs & ~dir);
    st_next.frame_prev_buttons = cur;
    st_next.frame_prev_dirs    = dir;

    // Publish on a game tick, step the hold count and repeat, then restart the accumulators.
    if (s1_tick) begin
      st_next.shown_before     = st_cur.tick_prev_buttons;
      st_next.shown_rise       = st_next.rise_accum;
      st_next.shown_fall       = st_next.fall_accum;
      st_next.shown_dir_before = st_cur.tick_prev_dirs;
      st_next.shown_dir_rise   = st_next.dir_rise_accum;
      st_next.shown_dir_fall   = st_next.dir_fall_accum;
      st_next.shown_repeat     = 1'b0;
      if (held_same) begin
        st_next.held_ticks   = held_inc;
        st_next.shown_repeat = (held_inc >= REPEAT_FIRST) &&
                               (mod5(held_inc) == REPEAT_PHASE);
      end else begin
        st_next.held_ticks = '0;
      end
      st_next.tick_prev_buttons = cur;
      st_next.tick_prev_dirs    = dir;
      st_next.rise_accum        = '0;
      st_next.fall_accum        = '0;
      st_next.dir_rise_accum    = '0;
      st_next.dir_fall_accum    = '0;
    end

    // Absent port: clear everything.
    if (!s1_present) begin
      st_next = '0;
    end
  end

  assign wr_en   = s1_adv && port_ok;
  assign wr_addr = s1_port[PORT_AW-1:0];
  assign wr_data = st_next;

  always_comb begin
    if (port_ok && s1_present) begin
      result = {7'b0, s1_ay, s1_ax, st_next.held_ticks, st_next.shown_repeat,
                st_next.shown_dir_before, st_next.shown_dir_fall,
                st_next.shown_dir_rise, dir,
                st_next.shown_before, st_next.shown_fall,
                st_next.shown_rise, cur};
    end else begin
      result = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A read that meets a write-back to the same port must pick up the bypass.
  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && (wr_addr == in_addr)) |=> s1_fwd_hit)
    else $error("same-port write-back was not forwarded");

  // An absent port yields an all-zero result.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !s1_present) |=> (m_tvalid && (m_tdata == '0)))
    else $error("absent port produced a nonzero result");

  // On a present sample the hold counter moves only on a game tick.
  a_hold_on_tick: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_present && !s1_tick) |->
      (st_next.held_ticks == st_cur.held_ticks))
    else $error("hold counter changed outside a game tick");
`endif

endmodule

// File: tb/sv/pad_qualifier_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pad qualifier scoreboard
// Request and result layouts plus a per-port model of the edge, tick and
// auto-repeat logic that keeps a queue of awaited results.
// ----------------------------------------------------------------------------
package pad_qualifier_tb_pkg;
  import gerq_pkg::*;

  // Request layout, lowest field last.
  typedef struct packed {
    logic [3:0]              pad;
    logic                    game_tick;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_x;
    logic [BTN_W-1:0]        buttons_raw;
    logic                    present;
    logic [PORT_W-1:0]       port_index;
  } sample_t;

  // Result layout, lowest field last.
  typedef struct packed {
    logic [6:0]               pad;
    logic signed [AXIS_W-1:0] axis_y_out;
    logic signed [AXIS_W-1:0] axis_x_out;
    logic [HOLD_W-1:0]        hold_count;
    logic                     repeat_pulse;
    logic [DIR_W-1:0]         dir_before;
    logic [DIR_W-1:0]         dir_fall;
    logic [DIR_W-1:0]         dir_rise;
    logic [DIR_W-1:0]         dir_now;
    logic [BTN_W-1:0]         button_before;
    logic [BTN_W-1:0]         button_fall;
    logic [BTN_W-1:0]         button_rise;
    logic [BTN_W-1:0]         button_now;
  } result_t;

  class pad_edge_scoreboard;
    logic [BTN_W-1:0]    mask;
    logic [THRESH_W-1:0] thresh;

    logic [BTN_W-1:0]  frame_btn [NUM_PORTS];
    logic [BTN_W-1:0]  rise_acc [NUM_PORTS];
    logic [BTN_W-1:0]  fall_acc [NUM_PORTS];
    logic [BTN_W-1:0]  tick_btn [NUM_PORTS];
    logic [DIR_W-1:0]  frame_dir [NUM_PORTS];
    logic [DIR_W-1:0]  drise_acc [NUM_PORTS];
    logic [DIR_W-1:0]  dfall_acc [NUM_PORTS];
    logic [DIR_W-1:0]  tick_dir [NUM_PORTS];
    logic [BTN_W-1:0]  pub_rise [NUM_PORTS];
    logic [BTN_W-1:0]  pub_fall [NUM_PORTS];
    logic [BTN_W-1:0]  pub_before [NUM_PORTS];
    logic [DIR_W-1:0]  pub_drise [NUM_PORTS];
    logic [DIR_W-1:0]  pub_dfall [NUM_PORTS];
    logic [DIR_W-1:0]  pub_dbefore [NUM_PORTS];
    logic              pub_repeat [NUM_PORTS];
    logic [HOLD_W-1:0] held [NUM_PORTS];

    result_t awaited_results [$];
    int errors;

    function new();
      mask   = MASK_RESET;
      thresh = THRESH_RESET;
      errors = 0;
      for (int p = 0; p < NUM_PORTS; p++) clear_port(p);
    endfunction

    function void clear_port(int p);
      frame_btn[p] = '0;  rise_acc[p] = '0;  fall_acc[p] = '0;  tick_btn[p] = '0;
      frame_dir[p] = '0;  drise_acc[p] = '0; dfall_acc[p] = '0; tick_dir[p] = '0;
      pub_rise[p] = '0;   pub_fall[p] = '0;  pub_before[p] = '0;
      pub_drise[p] = '0;  pub_dfall[p] = '0; pub_dbefore[p] = '0;
      pub_repeat[p] = 1'b0;
      held[p] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BUTTON_MASK: begin
          mask = data;
        end
        REG_STICK_THRESHOLD: begin
          thresh = data[THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_sample(sample_t s);
      result_t          r;
      int               p;
      int               x;
      int               y;
      int               th;
      int               c;
      logic [BTN_W-1:0] cur;
      logic [DIR_W-1:0] dir;
      r = '0;
      p = s.port_index;
      if (p >= NUM_PORTS) begin
        awaited_results.push_back(r);
        return;
      end
      if (!s.present) begin
        clear_port(p);
        awaited_results.push_back(r);
        return;
      end

      cur = s.buttons_raw & mask;
      x   = $signed(s.axis_x);
      y   = $signed(s.axis_y);
      th  = thresh;
      dir = '0;
      // Negative side wins; at most one bit per axis.
      if (x < -th) dir[DIR_LEFT] = 1'b1;
      else if (x > th) dir[DIR_RIGHT] = 1'b1;
      if (y < -th) dir[DIR_DOWN] = 1'b1;
      else if (y > th) dir[DIR_UP] = 1'b1;

      rise_acc[p]  |= cur & ~frame_btn[p];
      fall_acc[p]  |= frame_btn[p] & ~cur;
      drise_acc[p] |= dir & ~frame_dir[p];
      dfall_acc[p] |= frame_dir[p] & ~dir;
      frame_btn[p] = cur;
      frame_dir[p] = dir;

      if (s.game_tick) begin
        pub_before[p]  = tick_btn[p];
        pub_rise[p]    = rise_acc[p];
        pub_fall[p]    = fall_acc[p];
        pub_dbefore[p] = tick_dir[p];
        pub_drise[p]   = drise_acc[p];
        pub_dfall[p]   = dfall_acc[p];
        pub_repeat[p]  = 1'b0;
        if ((cur != '0 || dir != '0) && tick_btn[p] == cur && tick_dir[p] == dir) begin
          held[p] = held[p] + 1'b1;
          c = held[p];
          if (c >= int'(REPEAT_FIRST) && (c - int'(REPEAT_FIRST)) % REPEAT_EVERY == 0)
            pub_repeat[p] = 1'b1;
        end else begin
          held[p] = '0;
        end
        tick_btn[p]  = cur;
        tick_dir[p]  = dir;
        rise_acc[p]  = '0;
        fall_acc[p]  = '0;
        drise_acc[p] = '0;
        dfall_acc[p] = '0;
      end

      r.button_now    = cur;
      r.button_rise   = pub_rise[p];
      r.button_fall   = pub_fall[p];
      r.button_before = pub_before[p];
      r.dir_now       = dir;
      r.dir_rise      = pub_drise[p];
      r.dir_fall      = pub_dfall[p];
      r.dir_before    = pub_dbefore[p];
      r.repeat_pulse  = pub_repeat[p];
      r.hold_count    = held[p];
      r.axis_x_out    = s.axis_x;
      r.axis_y_out    = s.axis_y;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word);
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none actual %h", $time, word);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("button_now",    want.button_now,    got.button_now);
      compare_field("button_rise",   want.button_rise,   got.button_rise);
      compare_field("button_fall",   want.button_fall,   got.button_fall);
      compare_field("button_before", want.button_before, got.button_before);
      compare_field("dir_now",       want.dir_now,       got.dir_now);
      compare_field("dir_rise",      want.dir_rise,      got.dir_rise);
      compare_field("dir_fall",      want.dir_fall,      got.dir_fall);
      compare_field("dir_before",    want.dir_before,    got.dir_before);
      compare_field("repeat_pulse",  want.repeat_pulse,  got.repeat_pulse);
      compare_field("hold_count",    want.hold_count,    got.hold_count);
      compare_field("axis_x_out",    want.axis_x_out,    got.axis_x_out);
      compare_field("axis_y_out",    want.axis_y_out,    got.axis_y_out);
      compare_field("padding",       want.pad,           got.pad);
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gamepad edge and repeat qualifier testbench
// Drives pad samples and register writes into the qualifier with random
// gaps and back-pressure, predicts every result with a per-port model and
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import gerq_pkg::*;
  import pad_qualifier_tb_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int HOLD_OFF_CYCLES = 150;   // long receiver stall, fills the pipe
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int PRESSURE_PHASE  = 3;
  localparam int HOLD_TICKS      = 40;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Idle switches per phase; the stall request is picked up by the sink.
  bit src_idle      = 1'b0;
  bit sink_idle     = 1'b0;
  bit stall_pending = 1'b0;

  int stalled_cycles = 0;

  // Per-port scripted hold: the value held across ticks and ticks left.
  sample_t script_value [NUM_PORTS];
  int      script_left [NUM_PORTS];

  pad_edge_scoreboard sb = new();

  gamepad_edge_and_repeat_qualifier DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Observe every handshake at the clock edge. Register writes go first, then
  // the request, then the result, so that ordering never depends on which
  // process the simulator wakes first.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_sample(sample_t'(s_tdata));
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink: one assignment per pass, and each pass waits on the clock.
  initial begin
    forever begin
      if (stall_pending) begin
        // Hold off long enough for the block to fill and drop s_tready.
        stall_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic sample_t make_sample(int port, bit present, logic [15:0] buttons,
                                          int ax, int ay, bit tick);
    sample_t s;
    s             = '0;
    s.port_index  = PORT_W'(port);
    s.present     = present;
    s.buttons_raw = buttons;
    s.axis_x      = AXIS_W'(ax);
    s.axis_y      = AXIS_W'(ay);
    s.game_tick   = tick;
    return s;
  endfunction

  // Favor the threshold edges and the axis extremes.
  function automatic int pick_axis();
    int th;
    th = sb.thresh;
    case ($urandom_range(0, 7))
      0: return -128;
      1: return 127;
      2: return th;
      3: return th + 1;
      4: return -th;
      5: return -th - 1;
      default: return $signed(8'($urandom));
    endcase
  endfunction

  function automatic logic [15:0] pick_buttons();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly per-port held inputs with ticks, so hold counts climb past the
  // repeat point; frames between ticks may glitch. The rest is noise or unplugs.
  function automatic sample_t random_sample();
    sample_t s;
    int      p;
    int      roll;
    p    = $urandom_range(0, NUM_PORTS - 1);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      s     = sample_t'(IN_DATA_W'({$urandom, $urandom}));
      s.pad = '0;
      return s;
    end
    if (roll < 8) begin
      s            = sample_t'(IN_DATA_W'({$urandom, $urandom}));
      s.pad        = '0;
      s.port_index = PORT_W'(p);
      s.present    = 1'b0;
      script_left[p] = 0;
      return s;
    end
    if (script_left[p] == 0) begin
      script_value[p] = make_sample(p, 1'b1, pick_buttons(), pick_axis(), pick_axis(), 1'b1);
      script_left[p]  = $urandom_range(1, 40);
    end
    s = script_value[p];
    if ($urandom_range(0, 2) == 0) begin
      s.game_tick = 1'b1;
      script_left[p]--;
    end else begin
      s.game_tick = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        s.buttons_raw = 16'($urandom);
        s.axis_x      = AXIS_W'(pick_axis());
        s.axis_y      = AXIS_W'(pick_axis());
      end
    end
    return s;
  endfunction

  // Offer one request and hold it until it is taken.
  task automatic offer(input sample_t s);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tdata  <= s;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] mask_word, input logic [15:0] thresh_word);
    write_reg(REG_BUTTON_MASK, mask_word);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_STICK_THRESHOLD, thresh_word);
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every awaited result has come back. Step the
  // clock first so the monitor has noted the last request taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] mask_word;
    logic [15:0] thresh_word;
    sample_t     held_sample;

    for (int p = 0; p < NUM_PORTS; p++) script_left[p] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings first: mask drops bits 6 and 7,
    // threshold 50.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    offer(make_sample(0, 1'b1, 16'hFFFF, 127, -128, 1'b1));
    offer(make_sample(0, 1'b1, 16'h0000, -128, 127, 1'b0));  // release between ticks
    offer(make_sample(0, 1'b1, 16'h0000, 50, -50, 1'b1));    // exactly at threshold
    offer(make_sample(0, 1'b1, 16'h0000, 51, -51, 1'b1));    // just beyond it
    offer(make_sample(1, 1'b1, 16'h00C0, 0, 0, 1'b1));       // masked away: no input
    offer(make_sample(1, 1'b1, 16'h00C0, 0, 0, 1'b1));       // zero input never holds
    offer(make_sample(2, 1'b0, 16'hFFFF, -1, 1, 1'b1));      // absent port reads zero
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b0));
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b1));
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b1));
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b1));
    offer(make_sample(3, 1'b1, 16'h1234, 0, 0, 1'b0));       // stick glitch between ticks
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b1));
    offer(make_sample(3, 1'b0, 16'h0000, 0, 0, 1'b0));       // unplug clears the port
    offer(make_sample(3, 1'b1, 16'h1234, -51, 51, 1'b1));
    drain();

    // Full mask, threshold zero; upper data bits must not leak in.
    configure(16'hFFFF, 16'hFF80);
    offer(make_sample(0, 1'b1, 16'h0000, 0, 0, 1'b1));
    offer(make_sample(0, 1'b1, 16'hFFFF, 1, -1, 1'b1));
    offer(make_sample(0, 1'b1, 16'hFFFF, -1, 1, 1'b0));
    drain();

    // Empty mask, widest threshold: only -128 sets a direction.
    configure(16'h0000, 16'h007F);
    offer(make_sample(1, 1'b1, 16'hFFFF, 127, 127, 1'b1));
    offer(make_sample(1, 1'b1, 16'hFFFF, -128, -128, 1'b1));
    offer(make_sample(2, 1'b1, 16'hFFFF, -127, -128, 1'b1));
    drain();

    // Hold one input on port 2 across many ticks so repeat pulses fire at 15
    // and every 5th count after. Run it flat out.
    configure(16'hFFFF, 16'd50);
    src_idle    = 1'b0;
    sink_idle   = 1'b0;
    held_sample = make_sample(2, 1'b1, 16'h0001, 0, 0, 1'b1);
    for (int n = 0; n < HOLD_TICKS; n++) offer(held_sample);
    drain();

    // Random phases, one setting each, extremes first; the last runs with
    // no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          mask_word   = 16'hFFFF;
          thresh_word = 16'h0000;
        end
        1: begin
          mask_word   = 16'h0000;
          thresh_word = 16'hFFFF;
        end
        2: begin
          mask_word   = MASK_RESET;
          thresh_word = 16'(THRESH_RESET);
        end
        RANDOM_PHASES - 1: begin
          mask_word   = 16'hFFFF;
          thresh_word = 16'd64;
        end
        default: begin
          mask_word   = 16'($urandom);
          thresh_word = 16'($urandom);
        end
      endcase
      configure(mask_word, thresh_word);

      if (ph == 0) begin
        src_idle  = 1'b1;
        sink_idle = 1'b1;
      end else if (ph == RANDOM_PHASES - 1) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        src_idle  = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Keep offering while the sink holds off, so the input stalls.
        if (ph == PRESSURE_PHASE && n == 20) stall_pending = 1'b1;
        offer(random_sample());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
